// ----- rtl/core/assert_macros.svh -----
// assertion helpers for the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QS_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define QS_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/core/qslerp_pkg.sv -----
package qslerp_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int UNIT_BITS  = 30;
  localparam int SQRT_STEPS = 32;
  localparam int QUO_BITS   = 16;
  localparam int CFG_W      = 15;

  localparam logic [16:0] FRAC_ONE   = 17'd65536;
  localparam logic [14:0] THR_RESET  = 15'd15565;

  localparam logic signed [33:0] ANG_PI      = 34'sd3373259426;
  localparam logic signed [33:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_KINV = 34'sd652032874;

  localparam logic CFG_IDX_MODE = 1'b0;
  localparam logic CFG_IDX_THR  = 1'b1;

  typedef struct packed {
    logic signed [15:0] first_w;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] second_w;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;
    logic [16:0]        fraction;
  } in_t;

  typedef struct packed {
    logic signed [15:0] result_w;
    logic signed [15:0] result_x;
    logic signed [15:0] result_y;
    logic signed [15:0] result_z;
    logic               used_linear;
    logic               degenerate;
  } out_t;

  // values carried alongside the arithmetic
  typedef struct packed {
    logic [3:0][15:0] p;
    logic [3:0][16:0] q;
    logic [16:0]      t;
    logic [31:0]      c;
    logic [3:0][31:0] h;
    logic [31:0]      root;
    logic             lin;
    logic             degen;
  } side_t;

  function automatic logic signed [33:0] atan_val(input int idx);
    logic signed [33:0] v;
    case (idx)
      0:  v = 34'sh0_3243_F6A8;
      1:  v = 34'sh0_1DAC_6705;
      2:  v = 34'sh0_0FAD_BAFC;
      3:  v = 34'sh0_07F5_6EA6;
      4:  v = 34'sh0_03FE_AB76;
      5:  v = 34'sh0_01FF_D55B;
      6:  v = 34'sh0_00FF_FAAA;
      7:  v = 34'sh0_007F_FF55;
      8:  v = 34'sh0_003F_FFEA;
      9:  v = 34'sh0_001F_FFFD;
      10: v = 34'sh0_000F_FFFF;
      11: v = 34'sh0_0007_FFFF;
      12: v = 34'sh0_0003_FFFF;
      13: v = 34'sh0_0001_FFFF;
      14: v = 34'sh0_0000_FFFF;
      15: v = 34'sh0_0000_7FFF;
      16: v = 34'sh0_0000_3FFF;
      17: v = 34'sh0_0000_1FFF;
      18: v = 34'sh0_0000_0FFF;
      19: v = 34'sh0_0000_07FF;
      20: v = 34'sh0_0000_03FF;
      21: v = 34'sh0_0000_01FF;
      22: v = 34'sh0_0000_00FF;
      23: v = 34'sh0_0000_007F;
      24: v = 34'sh0_0000_003F;
      25: v = 34'sh0_0000_001F;
      26: v = 34'sh0_0000_000F;
      27: v = 34'sh0_0000_0007;
      28: v = 34'sh0_0000_0003;
      29: v = 34'sh0_0000_0001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/quaternion_slerp.sv -----
// Spherical interpolation of two quaternions (signed, 16384 = 1.0) by a fraction
// t (65536 = 1.0), with a normalized linear blend when the dot product reaches
// the threshold window or the two inputs are parallel. The pipeline takes one
// item per clock while the output is not stalled and has six setup stages, a
// 32-stage square root, an arccosine setup stage, ITERATIONS stages of
// arccosine rotation, three angle stages, ITERATIONS stages of the two sine
// rotations, three numerator stages, a 16-stage divider and the output register.
// A stall on the output freezes the whole pipeline; items are never lost.
`include "assert_macros.svh"

module quaternion_slerp #(
  parameter int ITERATIONS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  qslerp_pkg::in_t                     in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output qslerp_pkg::out_t                    out_data_o,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [qslerp_pkg::CFG_W-1:0]        cfg_wdata_i
);

  localparam int SQ = qslerp_pkg::SQRT_STEPS;
  localparam int QB = qslerp_pkg::QUO_BITS;
  localparam int IT = ITERATIONS;

  logic        mode_q;
  logic [14:0] thr_q;
  logic        adv;

  // stage 1
  logic signed [15:0] in_p [4];
  logic signed [15:0] in_q [4];
  logic [16:0]        in_t;
  logic               v1_q;
  logic signed [15:0] p1_q [4];
  logic signed [15:0] q1_q [4];
  logic [16:0]        t1_q;
  logic signed [31:0] pq1_q [4];

  // stage 2
  logic signed [33:0] d2_sum, d2a, thr_s, c_big;
  logic               neg2, sph2, sing2;
  qslerp_pkg::side_t  side2_d, side2_q;
  logic               v2_q;

  // stages 3 to 6
  logic signed [33:0] m1_q [4];
  logic signed [34:0] m2_q [4];
  logic [63:0]        csq3_q;
  qslerp_pkg::side_t  side3_q;
  logic               v3_q;
  qslerp_pkg::side_t  side4_d, side4_q;
  logic [63:0]        arg4_q;
  logic               v4_q;
  logic [63:0]        hsq5_q [4];
  logic [63:0]        arg5_q;
  qslerp_pkg::side_t  side5_q;
  logic               v5_q;
  logic [63:0]        hsum6;

  // square root
  logic               sq_v_q    [SQ+1];
  logic [63:0]        sq_n_q    [SQ+1];
  logic [63:0]        sq_r_q    [SQ+1];
  qslerp_pkg::side_t  sq_side_q [SQ+1];

  // arccosine
  logic [31:0]        root_ap;
  qslerp_pkg::side_t  side_ap;
  logic signed [33:0] c_ap;
  logic               ac_v_q    [IT+1];
  logic signed [33:0] ac_x_q    [IT+1];
  logic signed [33:0] ac_y_q    [IT+1];
  logic signed [33:0] ac_z_q    [IT+1];
  qslerp_pkg::side_t  ac_side_q [IT+1];

  // angle stages
  logic               cl_v_q;
  logic [31:0]        cl_a_q;
  qslerp_pkg::side_t  cl_side_q;
  logic               mt_v_q;
  logic [48:0]        mt_at_q;
  logic [31:0]        mt_a_q;
  qslerp_pkg::side_t  mt_side_q;
  logic [31:0]        ta_fd;
  logic [31:0]        b_fd [2];

  // sines
  logic               sn_v_q    [IT+1];
  logic signed [33:0] sn_x_q    [2][IT+1];
  logic signed [33:0] sn_y_q    [2][IT+1];
  logic signed [33:0] sn_z_q    [2][IT+1];
  qslerp_pkg::side_t  sn_side_q [IT+1];

  // numerator
  logic               nm_v_q;
  logic signed [51:0] mw1_q [4];
  logic signed [51:0] mw2_q [4];
  qslerp_pkg::side_t  nm_side_q;
  logic               nu_v_q;
  logic signed [51:0] num_q [4];
  qslerp_pkg::side_t  nu_side_q;
  logic [51:0]        mag_ab [4];

  // divider
  logic               dv_v_q    [QB+1];
  logic [47:0]        dv_rem_q  [4][QB+1];
  logic [QB-1:0]      dv_quo_q  [4][QB+1];
  logic [3:0]         dv_neg_q  [QB+1];
  logic [3:0]         dv_ovf_q  [QB+1];
  qslerp_pkg::side_t  dv_side_q [QB+1];

  // output
  logic               out_valid_q;
  qslerp_pkg::out_t   out_q;
  logic signed [15:0] res_o [4];

  assign adv         = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      thr_q  <= qslerp_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qslerp_pkg::CFG_IDX_MODE: mode_q <= cfg_wdata_i[0];
        qslerp_pkg::CFG_IDX_THR:  thr_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage 1: products of the dot
  assign in_p[0] = in_data_i.first_w;
  assign in_p[1] = in_data_i.first_x;
  assign in_p[2] = in_data_i.first_y;
  assign in_p[3] = in_data_i.first_z;
  assign in_q[0] = in_data_i.second_w;
  assign in_q[1] = in_data_i.second_x;
  assign in_q[2] = in_data_i.second_y;
  assign in_q[3] = in_data_i.second_z;
  assign in_t = (in_data_i.fraction > qslerp_pkg::FRAC_ONE) ? qslerp_pkg::FRAC_ONE
                                                            : in_data_i.fraction;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        p1_q[i]  <= in_p[i];
        q1_q[i]  <= in_q[i];
        pq1_q[i] <= in_p[i] * in_q[i];
      end
      t1_q <= in_t;
    end
  end

  // stage 2: dot, path choice, cosine
  always_comb begin
    d2_sum = 34'(pq1_q[0]) + 34'(pq1_q[1]) + 34'(pq1_q[2]) + 34'(pq1_q[3]);
    neg2   = mode_q && d2_sum[33];
    d2a    = neg2 ? -d2_sum : d2_sum;
    thr_s  = $signed({5'b0, thr_q, 14'b0});
    sph2   = mode_q ? (d2a < thr_s) : ((d2_sum > -thr_s) && (d2_sum < thr_s));
    c_big  = 34'sd268435456;
    sing2  = (d2a >= c_big) || (d2a <= -c_big);
    side2_d = '0;
    for (int i = 0; i < 4; i++) begin
      side2_d.p[i] = p1_q[i];
      side2_d.q[i] = neg2 ? -17'(q1_q[i]) : 17'(q1_q[i]);
    end
    side2_d.t   = t1_q;
    side2_d.lin = !sph2 || sing2;
    if (d2a > c_big) begin
      side2_d.c = 32'sh4000_0000;
    end else if (d2a < -c_big) begin
      side2_d.c = -32'sh4000_0000;
    end else begin
      side2_d.c = 32'(d2a <<< (qslerp_pkg::UNIT_BITS - 2 * qslerp_pkg::FRAC_BITS));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // stage 3: blend products and cosine square
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side2_q <= side2_d;
      for (int i = 0; i < 4; i++) begin
        m1_q[i] <= $signed(side2_q.p[i]) *
                   $signed({1'b0, 17'(qslerp_pkg::FRAC_ONE - side2_q.t)});
        m2_q[i] <= $signed(side2_q.q[i]) * $signed({1'b0, side2_q.t});
      end
      csq3_q  <= $signed(side2_q.c) * $signed(side2_q.c);
      side3_q <= side2_q;
    end
  end

  // stage 4: halved blend and sine square
  always_comb begin
    logic signed [34:0] hs;
    side4_d = side3_q;
    for (int i = 0; i < 4; i++) begin
      hs = 35'(m1_q[i]) + m2_q[i];
      side4_d.h[i] = 32'(hs >>> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side4_q <= side4_d;
      arg4_q  <= 64'h1000_0000_0000_0000 - csq3_q;
      for (int i = 0; i < 4; i++) begin
        hsq5_q[i] <= $signed(side4_q.h[i]) * $signed(side4_q.h[i]);
      end
      arg5_q  <= arg4_q;
      side5_q <= side4_q;
    end
  end

  // stage 6: root operand
  assign hsum6 = hsq5_q[0] + hsq5_q[1] + hsq5_q[2] + hsq5_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (adv) begin
      sq_v_q[0] <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_n_q[0]    <= side5_q.lin ? hsum6 : arg5_q;
      sq_r_q[0]    <= '0;
      sq_side_q[0] <= side5_q;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        take;
    assign trial = sq_r_q[k] + BIT;
    assign take  = sq_n_q[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_n_q[k+1]    <= take ? (sq_n_q[k] - trial) : sq_n_q[k];
        sq_r_q[k+1]    <= take ? ((sq_r_q[k] >> 1) + BIT) : (sq_r_q[k] >> 1);
        sq_side_q[k+1] <= sq_side_q[k];
      end
    end
  end

  // arccosine setup
  always_comb begin
    root_ap       = sq_r_q[SQ][31:0];
    side_ap       = sq_side_q[SQ];
    side_ap.root  = root_ap;
    side_ap.degen = side_ap.lin && (root_ap == '0);
    c_ap          = 34'($signed(side_ap.c));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac_v_q[0] <= 1'b0;
    end else if (adv) begin
      ac_v_q[0] <= sq_v_q[SQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (c_ap < 0) begin
        ac_x_q[0] <= $signed({2'b0, root_ap});
        ac_y_q[0] <= -c_ap;
        ac_z_q[0] <= qslerp_pkg::ANG_HALF_PI;
      end else begin
        ac_x_q[0] <= c_ap;
        ac_y_q[0] <= $signed({2'b0, root_ap});
        ac_z_q[0] <= '0;
      end
      ac_side_q[0] <= side_ap;
    end
  end

  for (genvar i = 0; i < IT; i++) begin : g_acos
    localparam logic signed [33:0] ATAN = qslerp_pkg::atan_val(i);
    logic signed [33:0] dx, dy;
    logic               up;
    assign dx = ac_y_q[i] >>> i;
    assign dy = ac_x_q[i] >>> i;
    assign up = ac_y_q[i] > 34'sd0;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ac_v_q[i+1] <= 1'b0;
      end else if (adv) begin
        ac_v_q[i+1] <= ac_v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ac_x_q[i+1]    <= up ? (ac_x_q[i] + dx) : (ac_x_q[i] - dx);
        ac_y_q[i+1]    <= up ? (ac_y_q[i] - dy) : (ac_y_q[i] + dy);
        ac_z_q[i+1]    <= up ? (ac_z_q[i] + ATAN) : (ac_z_q[i] - ATAN);
        ac_side_q[i+1] <= ac_side_q[i];
      end
    end
  end

  // angle clamp, scale by t, fold for sine
  assign ta_fd   = 32'(mt_at_q >> 16);
  assign b_fd[0] = mt_a_q - ta_fd;
  assign b_fd[1] = ta_fd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_v_q    <= 1'b0;
      mt_v_q    <= 1'b0;
      sn_v_q[0] <= 1'b0;
    end else if (adv) begin
      cl_v_q    <= ac_v_q[IT];
      mt_v_q    <= cl_v_q;
      sn_v_q[0] <= mt_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (ac_z_q[IT] < 0) begin
        cl_a_q <= '0;
      end else if (ac_z_q[IT] > qslerp_pkg::ANG_PI) begin
        cl_a_q <= 32'(qslerp_pkg::ANG_PI);
      end else begin
        cl_a_q <= 32'(ac_z_q[IT]);
      end
      cl_side_q <= ac_side_q[IT];
      mt_at_q   <= cl_a_q * cl_side_q.t;
      mt_a_q    <= cl_a_q;
      mt_side_q <= cl_side_q;
      for (int u = 0; u < 2; u++) begin
        sn_x_q[u][0] <= qslerp_pkg::CORDIC_KINV;
        sn_y_q[u][0] <= '0;
        if ({2'b0, b_fd[u]} > 34'(qslerp_pkg::ANG_HALF_PI)) begin
          sn_z_q[u][0] <= qslerp_pkg::ANG_PI - $signed({2'b0, b_fd[u]});
        end else begin
          sn_z_q[u][0] <= $signed({2'b0, b_fd[u]});
        end
      end
      sn_side_q[0] <= mt_side_q;
    end
  end

  // both sine weights, one rotation per stage
  for (genvar i = 0; i < IT; i++) begin : g_sin
    localparam logic signed [33:0] ATAN = qslerp_pkg::atan_val(i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sn_v_q[i+1] <= 1'b0;
      end else if (adv) begin
        sn_v_q[i+1] <= sn_v_q[i];
      end
    end

    for (genvar u = 0; u < 2; u++) begin : g_lane
      logic signed [33:0] dx, dy;
      logic               pos;
      assign dx  = sn_y_q[u][i] >>> i;
      assign dy  = sn_x_q[u][i] >>> i;
      assign pos = !sn_z_q[u][i][33];

      always_ff @(posedge clk_i) begin
        if (adv) begin
          sn_x_q[u][i+1] <= pos ? (sn_x_q[u][i] - dx) : (sn_x_q[u][i] + dx);
          sn_y_q[u][i+1] <= pos ? (sn_y_q[u][i] + dy) : (sn_y_q[u][i] - dy);
          sn_z_q[u][i+1] <= pos ? (sn_z_q[u][i] - ATAN) : (sn_z_q[u][i] + ATAN);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sn_side_q[i+1] <= sn_side_q[i];
      end
    end
  end

  // weighted sums and divider setup
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_ab[i] = num_q[i][51] ? 52'(-num_q[i]) : 52'(num_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_v_q    <= 1'b0;
      nu_v_q    <= 1'b0;
      dv_v_q[0] <= 1'b0;
    end else if (adv) begin
      nm_v_q    <= sn_v_q[IT];
      nu_v_q    <= nm_v_q;
      dv_v_q[0] <= nu_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        mw1_q[i] <= sn_y_q[0][IT] * $signed(sn_side_q[IT].p[i]);
        mw2_q[i] <= sn_y_q[1][IT] * $signed(sn_side_q[IT].q[i]);
        num_q[i] <= nm_side_q.lin
                  ? (52'($signed(nm_side_q.h[i])) <<< qslerp_pkg::FRAC_BITS)
                  : (mw1_q[i] + mw2_q[i]);
        dv_rem_q[i][0] <= mag_ab[i][47:0];
        dv_quo_q[i][0] <= '0;
        dv_neg_q[0][i] <= num_q[i][51];
        dv_ovf_q[0][i] <= mag_ab[i] >= {4'b0, nu_side_q.root, 16'b0};
      end
      nm_side_q    <= sn_side_q[IT];
      nu_side_q    <= nm_side_q;
      dv_side_q[0] <= nu_side_q;
    end
  end

  // restoring divide, most significant quotient bit first
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int SH = QB - 1 - j;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    for (genvar i = 0; i < 4; i++) begin : g_lane
      logic [47:0] trial;
      logic        take;
      assign trial = 48'(dv_side_q[j].root) << SH;
      assign take  = dv_rem_q[i][j] >= trial;

      always_ff @(posedge clk_i) begin
        if (adv) begin
          dv_rem_q[i][j+1] <= take ? (dv_rem_q[i][j] - trial) : dv_rem_q[i][j];
          dv_quo_q[i][j+1] <= {dv_quo_q[i][j][QB-2:0], take};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_neg_q[j+1]  <= dv_neg_q[j];
        dv_ovf_q[j+1]  <= dv_ovf_q[j];
        dv_side_q[j+1] <= dv_side_q[j];
      end
    end
  end

  // sign and saturation
  always_comb begin
    logic [QB-1:0] qv;
    for (int i = 0; i < 4; i++) begin
      qv = dv_quo_q[i][QB];
      if (dv_side_q[QB].degen) begin
        res_o[i] = '0;
      end else if (dv_ovf_q[QB][i]) begin
        res_o[i] = dv_neg_q[QB][i] ? -16'sd32768 : 16'sd32767;
      end else if (dv_neg_q[QB][i]) begin
        res_o[i] = (qv > 16'd32768) ? -16'sd32768 : 16'(17'd0 - {1'b0, qv});
      end else begin
        res_o[i] = (qv > 16'd32767) ? 16'sd32767 : $signed(qv);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_v_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.result_w    <= res_o[0];
      out_q.result_x    <= res_o[1];
      out_q.result_y    <= res_o[2];
      out_q.result_z    <= res_o[3];
      out_q.used_linear <= dv_side_q[QB].lin;
      out_q.degenerate  <= dv_side_q[QB].degen;
    end
  end

  `QS_ASSERT_IMP(a_degen_lin, out_valid_q && out_q.degenerate, out_q.used_linear, "degenerate item off linear path")
  `QS_ASSERT_IMP(a_degen_zero, out_valid_q && out_q.degenerate, out_q.result_w == '0 && out_q.result_x == '0 && out_q.result_y == '0 && out_q.result_z == '0, "degenerate item with nonzero result")
  `QS_ASSERT_IMP(a_sph_div, dv_v_q[0] && !dv_side_q[0].lin, dv_side_q[0].root != '0, "zero divisor on spherical path")
  `QS_ASSERT_IMP(a_root_width, sq_v_q[SQ], sq_r_q[SQ][63:32] == '0, "root exceeds 32 bits")
  `QS_ASSERT_NXT(a_out_hold, out_valid_q && out_stall_i, out_valid_q, "stalled result dropped")

endmodule

// ----- tb/sv/quaternion_slerp_tb.sv -----
module quaternion_slerp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qslerp_pkg::*;

  localparam int       NUM_ROT   = 16;
  localparam longint   CYCLE_CAP = 600000;
  localparam int       DRAIN_GAP = 150;
  localparam int       HOLD_LEN  = 500;
  localparam int       HOLD_AT   = 1250;
  localparam longint   U_ONE     = 64'sd1 << UNIT_BITS;
  localparam longint   T_ONE     = 64'sd65536;
  localparam longint   PI_A      = 64'sd3373259426;
  localparam longint   HPI_A     = 64'sd1686629713;
  localparam longint   K_INV     = 64'sd652032874;

  localparam longint ATAN_LUT [NUM_ROT] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
  };

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  quaternion_slerp i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  in_t    pending_items[$];
  out_t   expected_quats[$];
  bit     shortest_mode;
  logic [14:0] dot_thresh;
  int     items_queued;
  int     items_taken;
  int     fail_count;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_left;
  bit     hold_done;
  longint cycle_count;

  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = 1'b1;
      #5 clk_i = 1'b0;
    end
  end

  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint rot_sine(longint ang);
    longint x, y, z, dx, dy;
    x = K_INV;
    y = 0;
    if (ang > HPI_A) ang = PI_A - ang;
    if (ang < 0) ang = 0;
    z = ang;
    for (int i = 0; i < NUM_ROT; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_LUT[i];
      end else begin
        x += dx; y -= dy; z += ATAN_LUT[i];
      end
    end
    return y;
  endfunction

  function automatic longint rot_arccos(longint cv, longint sv);
    longint x, y, z, dx, dy, tmp;
    x = cv;
    y = sv;
    z = 0;
    if (x < 0) begin
      tmp = x; x = y; y = -tmp; z = HPI_A;
    end
    for (int i = 0; i < NUM_ROT; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_LUT[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_LUT[i];
      end
    end
    if (z < 0) z = 0;
    if (z > PI_A) z = PI_A;
    return z;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic out_t slerp_predict(in_t it, bit mode, logic [14:0] thr_reg);
    longint p[4], q[4], r[4], h[4];
    longint dot, thr, t, cv, sv, ang, tang, w1, w2;
    longint unsigned sum, len;
    bit sph, lin, degen;
    out_t o;
    p[0] = longint'($signed(it.first_w));
    p[1] = longint'($signed(it.first_x));
    p[2] = longint'($signed(it.first_y));
    p[3] = longint'($signed(it.first_z));
    q[0] = longint'($signed(it.second_w));
    q[1] = longint'($signed(it.second_x));
    q[2] = longint'($signed(it.second_y));
    q[3] = longint'($signed(it.second_z));
    dot = 0;
    for (int i = 0; i < 4; i++) dot += p[i] * q[i];
    t = longint'(it.fraction);
    if (t > T_ONE) t = T_ONE;
    thr = longint'(thr_reg) << FRAC_BITS;
    lin = 1'b0;
    degen = 1'b0;
    if (mode) begin
      if (dot < 0) begin
        dot = -dot;
        for (int i = 0; i < 4; i++) q[i] = -q[i];
      end
      sph = dot < thr;
    end else begin
      sph = (dot > -thr) && (dot < thr);
    end
    if (sph) begin
      cv = dot * 4;
      if (cv > U_ONE) cv = U_ONE;
      if (cv < -U_ONE) cv = -U_ONE;
      sv = longint'(int_sqrt(longint'(U_ONE * U_ONE) - cv * cv));
      if (sv == 0) begin
        sph = 1'b0;
      end else begin
        ang = rot_arccos(cv, sv);
        tang = (ang * t) >>> 16;
        w1 = rot_sine(ang - tang);
        w2 = rot_sine(tang);
        for (int i = 0; i < 4; i++) r[i] = (w1 * p[i] + w2 * q[i]) / sv;
      end
    end
    if (!sph) begin
      lin = 1'b1;
      sum = 0;
      for (int i = 0; i < 4; i++) begin
        h[i] = floor_shr(p[i] * (T_ONE - t) + q[i] * t, 1);
        sum += longint'(h[i] * h[i]);
      end
      len = int_sqrt(sum);
      if (len == 0) begin
        degen = 1'b1;
        for (int i = 0; i < 4; i++) r[i] = 0;
      end else begin
        for (int i = 0; i < 4; i++) r[i] = (h[i] * (64'sd1 << FRAC_BITS)) / longint'(len);
      end
    end
    o.result_w = clip16(r[0]);
    o.result_x = clip16(r[1]);
    o.result_y = clip16(r[2]);
    o.result_z = clip16(r[3]);
    o.used_linear = lin;
    o.degenerate = degen;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_quats.push_back(slerp_predict(in_data_i, shortest_mode, dot_thresh));
      items_taken++;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= (hold_left > 1);
    end else if (!hold_done && items_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_t exp_q;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_quats.size() == 0) begin
        $error("unexpected item %p", out_data_o);
        fail_count++;
      end else begin
        exp_q = expected_quats.pop_front();
        if (out_data_o.result_w !== exp_q.result_w) begin
          $error("result_w exp %0d got %0d", exp_q.result_w, out_data_o.result_w);
          fail_count++;
        end
        if (out_data_o.result_x !== exp_q.result_x) begin
          $error("result_x exp %0d got %0d", exp_q.result_x, out_data_o.result_x);
          fail_count++;
        end
        if (out_data_o.result_y !== exp_q.result_y) begin
          $error("result_y exp %0d got %0d", exp_q.result_y, out_data_o.result_y);
          fail_count++;
        end
        if (out_data_o.result_z !== exp_q.result_z) begin
          $error("result_z exp %0d got %0d", exp_q.result_z, out_data_o.result_z);
          fail_count++;
        end
        if (out_data_o.used_linear !== exp_q.used_linear) begin
          $error("used_linear exp %0b got %0b", exp_q.used_linear, out_data_o.used_linear);
          fail_count++;
        end
        if (out_data_o.degenerate !== exp_q.degenerate) begin
          $error("degenerate exp %0b got %0b", exp_q.degenerate, out_data_o.degenerate);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // idle mix follows progress through the run
  always @(posedge clk_i) begin
    if (items_taken < 550) begin
      send_idle_pct = 19;
      recv_idle_pct = 88;
    end else if (items_taken < 1100) begin
      send_idle_pct = 88;
      recv_idle_pct = 19;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  task automatic queue_item(logic [15:0] pw, px, py, pz, qw, qx, qy, qz, logic [16:0] fr);
    in_t it;
    it = '{pw, px, py, pz, qw, qx, qy, qz, fr};
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_IDX_MODE) shortest_mode = val[0];
    else dot_thresh = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_all();
    wait (items_taken == items_queued && expected_quats.size() == 0);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  function automatic logic [16:0] rand_fraction();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 17'd0;
    if (k == 1) return FRAC_ONE;
    if (k == 2) return 17'($urandom_range(131071));
    return 17'($urandom_range(65536));
  endfunction

  task automatic queue_random();
    real a[4], b[4], n;
    int k, spread;
    logic [15:0] pv[4], qv[4];
    k = $urandom_range(9);
    if (k < 2) begin
      for (int i = 0; i < 4; i++) begin
        pv[i] = 16'($urandom);
        qv[i] = 16'($urandom);
      end
    end else begin
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
        a[i] = real'(int'($urandom_range(65535)) - 32768);
        n += a[i] * a[i];
      end
      if (n < 1.0) begin
        a[0] = 1.0;
        n = 1.0;
      end
      n = $sqrt(n);
      for (int i = 0; i < 4; i++) a[i] = a[i] / n * 16384.0;
      spread = (k < 6) ? 40000 : $urandom_range(3000);
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
        b[i] = a[i] + real'(int'($urandom_range(2 * spread)) - spread);
        n += b[i] * b[i];
      end
      if (n < 1.0) begin
        b[0] = 1.0;
        n = 1.0;
      end
      n = $sqrt(n);
      for (int i = 0; i < 4; i++) begin
        b[i] = b[i] / n * 16384.0;
        if ($urandom_range(1)) b[i] = -b[i];
        pv[i] = 16'($rtoi(a[i]));
        qv[i] = 16'($rtoi(b[i]));
      end
      if ($urandom_range(1)) for (int i = 0; i < 4; i++) qv[i] = 16'(-$signed(qv[i]));
    end
    queue_item(pv[0], pv[1], pv[2], pv[3], qv[0], qv[1], qv[2], qv[3], rand_fraction());
  endtask

  task automatic queue_directed();
    queue_item(0, 0, 0, 0, 0, 0, 0, 0, 17'd32768);
    queue_item(16384, 0, 0, 0, 16384, 0, 0, 0, 17'd32768);
    queue_item(16384, 0, 0, 0, -16384, 0, 0, 0, 17'd32768);
    queue_item(16384, 0, 0, 0, 0, 16384, 0, 0, 17'd0);
    queue_item(16384, 0, 0, 0, 0, 16384, 0, 0, FRAC_ONE);
    queue_item(16384, 0, 0, 0, 0, 16384, 0, 0, 17'h1FFFF);
    queue_item(16384, 0, 0, 0, 0, 16384, 0, 0, 17'd32768);
    queue_item(11585, 11585, 0, 0, -11585, 0, 11585, 0, 17'd21845);
    queue_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
               16'h7FFF, 17'd1);
    queue_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
               16'h8000, 17'd65535);
    queue_item(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
               16'h8000, 17'd40000);
    queue_item(16'h7FFF, 0, 0, 0, 0, 16'h7FFF, 0, 0, 17'd30000);
    queue_item(1, 0, 0, 0, 0, 0, 0, 1, 17'd32768);
    queue_item(16384, 0, 0, 0, 16384, 0, 0, 0, 17'd0);
    queue_item(16384, 0, 0, 0, -16384, 0, 0, 0, FRAC_ONE);
    queue_item(16384, 0, 0, 0, 15565, 5115, 0, 0, 17'd10000);
    queue_item(16384, 0, 0, 0, -15565, 5115, 0, 0, 17'd50000);
    queue_item(0, 0, 16384, 0, 0, 0, 0, 16384, 17'd65536);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_IDX_MODE;
    cfg_wdata_i = '0;
    shortest_mode = 1'b1;
    dot_thresh = THR_RESET;
    items_queued = 0;
    items_taken = 0;
    fail_count = 0;
    cycle_count = 0;
    send_idle_pct = 19;
    recv_idle_pct = 88;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_directed();
    for (int i = 0; i < 300; i++) queue_random();
    drain_all();

    write_reg(CFG_IDX_MODE, 0);
    write_reg(CFG_IDX_THR, 15'd16384);
    queue_directed();
    for (int i = 0; i < 300; i++) queue_random();
    drain_all();

    write_reg(CFG_IDX_MODE, 1);
    write_reg(CFG_IDX_THR, 15'd0);
    for (int i = 0; i < 250; i++) queue_random();
    drain_all();

    write_reg(CFG_IDX_MODE, 0);
    for (int i = 0; i < 250; i++) queue_random();
    drain_all();

    write_reg(CFG_IDX_THR, 15'd12000);
    queue_directed();
    for (int i = 0; i < 250; i++) queue_random();
    drain_all();

    write_reg(CFG_IDX_MODE, 1);
    write_reg(CFG_IDX_THR, 15'd16384);
    for (int i = 0; i < 250; i++) queue_random();
    drain_all();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
